// ===== hw/rtl/vn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_pkg
// Shared widths, sizes and helpers for the vector normalizer.
// ----------------------------------------------------------------------------
package vn_pkg;

  localparam int unsigned MAX_LEN    = 16;
  localparam int unsigned IDX_W      = $clog2(MAX_LEN);
  localparam int unsigned CNT_W      = $clog2(MAX_LEN + 1);

  localparam int unsigned ELEM_W     = 32;
  localparam int unsigned PROD_W     = 2 * ELEM_W;
  localparam int unsigned SUM_W      = 68;
  localparam int unsigned ROOT_W     = SUM_W / 2;
  localparam int unsigned SQ_REM_W   = ROOT_W + 3;
  localparam int unsigned SQ_CNT_W   = $clog2(ROOT_W);
  localparam int unsigned MAG_W      = 35;

  localparam int unsigned FRAC_W     = 30;
  localparam int unsigned QUO_W      = FRAC_W + 1;
  localparam int unsigned DIV_REM_W  = ROOT_W + 1;
  localparam int unsigned DIV_CNT_W  = $clog2(QUO_W);

  // Unsigned magnitude of a two's complement element; the most negative
  // value maps to 2^31.
  function automatic logic [ELEM_W-1:0] abs_mag(input logic [ELEM_W-1:0] v);
    logic [ELEM_W-1:0] r;
    r = v[ELEM_W-1] ? (~v + ELEM_W'(1)) : v;
    return r;
  endfunction

endpackage

// ===== hw/rtl/vector_normalizer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_normalizer_top
// L2 normalization of a vector of Q16.16 elements into Q2.30 unit values.
//
// Input channel (in_valid_i/in_ready_o): one element per transfer, last_i
// closes the vector. Elements are taken one per cycle while loading; up to
// 16 are stored, further ones are dropped and too_long_o is set on the run.
// Output channel (out_valid_o/out_ready_i): one result per stored element,
// last_res_o on the final one. A zero vector gives a single result with
// zero_vector_o set.
// Flow: after the last transfer, the squaring pipeline (mag_q, prod_q)
// drains into sum_q and the root unit then computes the 34 root bits.
// Each result is then computed by the 31-step serial divider. The result
// sits in an output register; a stalled receiver holds it and the block
// waits there. After the final result is loaded the block takes new
// elements at once. Reset empties the vector and the output.
// ----------------------------------------------------------------------------
module vector_normalizer_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [vn_pkg::ELEM_W-1:0]   element_i,
  input  logic                               last_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [vn_pkg::ELEM_W-1:0]   unit_value_o,
  output logic [vn_pkg::MAG_W-1:0]           magnitude_o,
  output logic                               last_res_o,
  output logic                               zero_vector_o,
  output logic                               too_long_o
);

  typedef enum logic [2:0] {
    ST_LOAD, ST_DRAIN, ST_ROOT, ST_ZERO, ST_DIVSTART, ST_DIVWAIT, ST_EMIT
  } state_e;

  state_e state_q;

  logic [vn_pkg::ELEM_W-1:0] store_q [vn_pkg::MAX_LEN];

  logic [vn_pkg::CNT_W-1:0]  count_q;
  logic [vn_pkg::IDX_W-1:0]  idx_q;
  logic                      ovf_q;
  logic [vn_pkg::ELEM_W-1:0] mag_q;
  logic                      mag_v_q;
  logic [vn_pkg::PROD_W-1:0] prod_q;
  logic                      prod_v_q;
  logic [vn_pkg::SUM_W-1:0]  sum_q;
  logic [vn_pkg::ROOT_W-1:0] norm_q;
  logic                      neg_q;

  logic                      out_valid_q;
  logic [vn_pkg::ELEM_W-1:0] unit_value_q;
  logic [vn_pkg::MAG_W-1:0]  magnitude_q;
  logic                      last_res_q;
  logic                      zero_vector_q;
  logic                      too_long_q;

  logic                      in_xfer;
  logic                      has_room;
  logic                      out_free;
  logic                      sqrt_start;
  logic                      sqrt_done;
  logic [vn_pkg::ROOT_W-1:0] sqrt_root;
  logic                      div_start;
  logic                      div_done;
  logic [vn_pkg::QUO_W-1:0]  div_quo;
  logic [vn_pkg::ELEM_W-1:0] rd_elem;
  logic [vn_pkg::ELEM_W-1:0] quo_ext;
  logic                      is_final;

  assign in_ready_o = (state_q == ST_LOAD);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign has_room   = (count_q < vn_pkg::CNT_W'(vn_pkg::MAX_LEN));
  assign out_free   = !out_valid_q || out_ready_i;
  assign sqrt_start = (state_q == ST_DRAIN) && !mag_v_q && !prod_v_q;
  assign div_start  = (state_q == ST_DIVSTART);
  assign rd_elem    = store_q[idx_q];
  assign quo_ext    = {1'b0, div_quo};
  assign is_final   = ((vn_pkg::CNT_W'(idx_q) + vn_pkg::CNT_W'(1)) == count_q);

  vn_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (sum_q),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  vn_divider u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .mag_i     (vn_pkg::abs_mag(rd_elem)),
    .divisor_i (norm_q),
    .done_o    (div_done),
    .quo_o     (div_quo)
  );

  always_ff @(posedge clk_i) begin
    if (in_xfer && has_room) begin
      store_q[count_q[vn_pkg::IDX_W-1:0]] <= element_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_LOAD;
      count_q       <= '0;
      idx_q         <= '0;
      ovf_q         <= 1'b0;
      mag_q         <= '0;
      mag_v_q       <= 1'b0;
      prod_q        <= '0;
      prod_v_q      <= 1'b0;
      sum_q         <= '0;
      norm_q        <= '0;
      neg_q         <= 1'b0;
      out_valid_q   <= 1'b0;
      unit_value_q  <= '0;
      magnitude_q   <= '0;
      last_res_q    <= 1'b0;
      zero_vector_q <= 1'b0;
      too_long_q    <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      // square and accumulate pipeline
      mag_v_q  <= 1'b0;
      prod_v_q <= mag_v_q;
      if (mag_v_q) begin
        prod_q <= vn_pkg::PROD_W'(mag_q) * vn_pkg::PROD_W'(mag_q);
      end
      if (prod_v_q) begin
        sum_q <= sum_q + {{(vn_pkg::SUM_W - vn_pkg::PROD_W){1'b0}}, prod_q};
      end

      case (state_q)
        ST_LOAD: begin
          if (in_xfer) begin
            if (has_room) begin
              mag_q   <= vn_pkg::abs_mag(element_i);
              mag_v_q <= 1'b1;
              count_q <= count_q + vn_pkg::CNT_W'(1);
            end else begin
              ovf_q <= 1'b1;
            end
            if (last_i) begin
              state_q <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (sqrt_start) begin
            state_q <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (sqrt_done) begin
            norm_q <= sqrt_root;
            idx_q  <= '0;
            if (sqrt_root == '0) begin
              state_q <= ST_ZERO;
            end else begin
              state_q <= ST_DIVSTART;
            end
          end
        end
        ST_ZERO: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            unit_value_q  <= '0;
            magnitude_q   <= '0;
            last_res_q    <= 1'b1;
            zero_vector_q <= 1'b1;
            too_long_q    <= ovf_q;
            sum_q         <= '0;
            count_q       <= '0;
            ovf_q         <= 1'b0;
            state_q       <= ST_LOAD;
          end
        end
        ST_DIVSTART: begin
          neg_q   <= rd_elem[vn_pkg::ELEM_W-1];
          state_q <= ST_DIVWAIT;
        end
        ST_DIVWAIT: begin
          if (div_done) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            unit_value_q  <= neg_q ? (~quo_ext + vn_pkg::ELEM_W'(1)) : quo_ext;
            magnitude_q   <= vn_pkg::MAG_W'(norm_q);
            last_res_q    <= is_final;
            zero_vector_q <= 1'b0;
            too_long_q    <= ovf_q;
            if (is_final) begin
              sum_q   <= '0;
              count_q <= '0;
              ovf_q   <= 1'b0;
              state_q <= ST_LOAD;
            end else begin
              idx_q   <= idx_q + vn_pkg::IDX_W'(1);
              state_q <= ST_DIVSTART;
            end
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign unit_value_o  = unit_value_q;
  assign magnitude_o   = magnitude_q;
  assign last_res_o    = last_res_q;
  assign zero_vector_o = zero_vector_q;
  assign too_long_o    = too_long_q;

  a_zero_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_vector_o |-> last_res_o && unit_value_o == '0 && magnitude_o == '0)
    else $error("zero vector result malformed");

  a_norm_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !zero_vector_o |-> magnitude_o != '0)
    else $error("nonzero result with zero norm");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> unit_value_o <= 32'sd1073741824 && unit_value_o >= -32'sd1073741824)
    else $error("unit value out of range");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= vn_pkg::CNT_W'(vn_pkg::MAX_LEN))
    else $error("element count beyond store depth");

  a_root_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> state_q == ST_ROOT)
    else $error("square root finished outside root phase");

endmodule

// ===== hw/rtl/vn_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_isqrt
// Floored integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module vn_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [vn_pkg::SUM_W-1:0]   radicand_i,
  output logic                       done_o,
  output logic [vn_pkg::ROOT_W-1:0]  root_o
);

  logic [vn_pkg::SUM_W-1:0]    rad_q;
  logic [vn_pkg::SQ_REM_W-1:0] rem_q;
  logic [vn_pkg::ROOT_W-1:0]   root_q;
  logic [vn_pkg::SQ_CNT_W-1:0] cnt_q;
  logic                        busy_q;
  logic                        done_q;

  logic [vn_pkg::SQ_REM_W-1:0] rem_sh;
  logic [vn_pkg::SQ_REM_W-1:0] trial;
  logic                        ge;

  assign rem_sh = {rem_q[vn_pkg::SQ_REM_W-3:0], rad_q[vn_pkg::SUM_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rad_q  <= radicand_i;
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= vn_pkg::SQ_CNT_W'(vn_pkg::ROOT_W - 1);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rad_q  <= {rad_q[vn_pkg::SUM_W-3:0], 2'b00};
        rem_q  <= ge ? (rem_sh - trial) : rem_sh;
        root_q <= {root_q[vn_pkg::ROOT_W-2:0], ge};
        cnt_q  <= cnt_q - vn_pkg::SQ_CNT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== hw/rtl/vn_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_divider
// Restoring bit-serial divider: (mag << 30) / divisor, one quotient bit
// per cycle. Requires mag <= divisor.
// ----------------------------------------------------------------------------
module vn_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [vn_pkg::ELEM_W-1:0]   mag_i,
  input  logic [vn_pkg::ROOT_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [vn_pkg::QUO_W-1:0]    quo_o
);

  logic [vn_pkg::DIV_REM_W-1:0] rem_q;
  logic [vn_pkg::QUO_W-1:0]     sh_q;
  logic [vn_pkg::QUO_W-1:0]     quo_q;
  logic [vn_pkg::ROOT_W-1:0]    div_q;
  logic [vn_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                         busy_q;
  logic                         done_q;

  logic [vn_pkg::DIV_REM_W-1:0] rem_sh;
  logic [vn_pkg::DIV_REM_W-1:0] div_ext;
  logic                         ge;

  assign rem_sh  = {rem_q[vn_pkg::DIV_REM_W-2:0], sh_q[vn_pkg::QUO_W-1]};
  assign div_ext = {1'b0, div_q};
  assign ge      = (rem_sh >= div_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      sh_q   <= '0;
      quo_q  <= '0;
      div_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= {{(vn_pkg::DIV_REM_W - vn_pkg::ELEM_W + 1){1'b0}},
                   mag_i[vn_pkg::ELEM_W-1:1]};
        sh_q   <= {mag_i[0], {vn_pkg::FRAC_W{1'b0}}};
        quo_q  <= '0;
        div_q  <= divisor_i;
        cnt_q  <= vn_pkg::DIV_CNT_W'(vn_pkg::QUO_W - 1);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q  <= ge ? (rem_sh - div_ext) : rem_sh;
        sh_q   <= {sh_q[vn_pkg::QUO_W-2:0], 1'b0};
        quo_q  <= {quo_q[vn_pkg::QUO_W-2:0], ge};
        cnt_q  <= cnt_q - vn_pkg::DIV_CNT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
